// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CHK_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHK_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CHK_IMPLY(name, clk, rst, ante, cons, msg)
`define CHK_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants for the checksummed frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam int MAX_PAYLOAD_DEF = 64;

   // request modes
   localparam logic [1:0] MODE_BYTE    = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_STATUS  = 2'd2;

   // CSR map
   localparam int         CSR_ADDR_W   = 3;
   localparam int         CSR_DATA_W   = 32;
   localparam int         CSR_IDX_BIT  = 2;
   localparam logic       CSR_HEAD1    = 1'b0;
   localparam logic       CSR_HEAD2    = 1'b1;
   localparam logic [7:0] HEAD1_RESET  = 8'd170;
   localparam logic [7:0] HEAD2_RESET  = 8'd85;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  frame_command;
      logic [6:0]  frame_length;
      logic [5:0]  byte_index;
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        last;
      logic [31:0] error_count;
      logic        frame_held;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_HEAD1 = 3'd0,
      PH_HEAD2 = 3'd1,
      PH_CMD   = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_byte;
      logic release_frame;
      logic load_status;
      logic load_marker;
      logic start_read;
      logic next_read;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic frame_good;
      logic frame_empty;
      logic rsp_last;
   } sts_type;

endpackage

// ===== hdl/checksummed_frame_deframer.sv =====
// A byte or release transaction is absorbed when it is accepted; a status result is
//   valid in the cycle after its request is accepted.
// Frame drain: each payload result is a store read (ST_READ), then output (ST_SEND),
//   where rsp_ready stalls can hold it; a zero-length marker goes straight to output.
// Requests wait while a result run is pending. Reset (synchronous): parser hunts head1,
//   held flag and drop count clear, headers go to 0xAA / 0x55; payload store is kept.
// ----------------------------------------------------------------------------
// checksummed_frame_deframer
// Finds head1/head2/command/length/payload/check frames in a byte stream,
// verifies the 8-bit sum check and emits good frames as payload runs.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer #(
   parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cfd_pkg::req_type                req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cfd_pkg::rsp_type                rsp_data,
   // CSR port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cfd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cfd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import cfd_pkg::*;

   logic [7:0] head1_ff, head1_in;
   logic [7:0] head2_ff, head2_in;
   logic       csr_wr;
   logic       csr_idx;
   cmd_type    cmd;
   sts_type    sts;

   // ---- CSR block: two header match bytes, no wait states ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_IDX_BIT];   // byte-offset bits are don't-care

   always_comb begin
      head1_in = head1_ff;
      head2_in = head2_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_HEAD1: head1_in = csr_pwdata[7:0];
            CSR_HEAD2: head2_in = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head1_ff <= HEAD1_RESET;
         head2_ff <= HEAD2_RESET;
      end else begin
         head1_ff <= head1_in;
         head2_ff <= head2_in;
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_HEAD1: csr_prdata = {24'd0, head1_ff};
         CSR_HEAD2: csr_prdata = {24'd0, head2_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // ---- sequencer: owns both handshakes ----
   cfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // ---- parser, payload store and result fields ----
   cfd_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .head1    (head1_ff),
      .head2    (head2_ff),
      .rx_byte  (req_data.rx_byte),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/cfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfd_ctrl
// Sequencer: accepts requests, starts result runs, paces the payload drain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_mode,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cfd_pkg::sts_type sts,
   output cfd_pkg::cmd_type cmd
);
   import cfd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_BYTE && sts.frame_good) begin
                  state_in = sts.frame_empty ? ST_SEND : ST_READ;
               end else if (req_mode == MODE_STATUS) begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               state_in = sts.rsp_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_mode)
                  MODE_BYTE: begin
                     cmd.take_byte = 1'b1;
                     if (sts.frame_good) begin
                        cmd.load_marker = sts.frame_empty;
                        cmd.start_read  = !sts.frame_empty;
                     end
                  end
                  MODE_RELEASE: begin
                     cmd.release_frame = 1'b1;
                  end
                  MODE_STATUS: begin
                     cmd.load_status = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready && !sts.rsp_last) begin
               cmd.next_read = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   `CHK_IMPLY(a_no_overlap, clock, reset, rsp_valid, !req_ready, "accepting while a result is pending")
   `CHK_NEXT(a_read_then_send, clock, reset, state_ff == ST_READ, rsp_valid, "memory read not followed by a result")
   `CHK_IMPLY(a_one_load, clock, reset, 1'b1, $onehot0({cmd.load_status, cmd.load_marker, cmd.start_read}), "conflicting result loads")

endmodule

// ===== hdl/cfd_datapath.sv =====
// ----------------------------------------------------------------------------
// cfd_datapath
// Frame parser, checksum, payload store, counters and result fields.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfd_datapath #(
   parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       head1,
   input  logic [7:0]       head2,
   input  logic [7:0]       rx_byte,
   input  cfd_pkg::cmd_type cmd,
   output cfd_pkg::sts_type sts,
   output cfd_pkg::rsp_type rsp_data
);
   import cfd_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   phase_type   phase_ff, phase_in;
   logic        held_ff, held_in;
   logic [31:0] drop_ff, drop_in;
   logic        kind_ff, kind_in;
   logic        marker_ff, marker_in;
   logic [7:0]  command_ff, command_in;
   logic [6:0]  length_ff, length_in;
   logic [6:0]  fill_ff, fill_in;
   logic [7:0]  sum_ff, sum_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]  rd_data_ff;
   logic [7:0]  mem [MAX_PAYLOAD];

   logic [7:0]  sum_next;
   logic [6:0]  fill_next;
   logic        mem_we;
   logic        no_data;

   assign sum_next  = sum_ff + rx_byte;
   assign fill_next = fill_ff + 7'd1;
   assign mem_we    = cmd.take_byte && (phase_ff == PH_DATA);

   assign sts.frame_good  = (phase_ff == PH_CHECK) && (rx_byte == sum_ff) && !held_ff;
   assign sts.frame_empty = (length_ff == 7'd0);
   assign sts.rsp_last    = rsp_data.last;

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      drop_in    = drop_ff;
      command_in = command_ff;
      length_in  = length_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      if (cmd.release_frame) begin
         held_in = 1'b0;
      end
      if (cmd.take_byte) begin
         case (phase_ff)
            PH_HEAD2: begin
               phase_in = (rx_byte == head2) ? PH_CMD : PH_HEAD1;
            end
            PH_CMD: begin
               command_in = rx_byte;
               sum_in     = rx_byte;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               sum_in  = sum_next;
               fill_in = 7'd0;
               if (rx_byte > 8'(MAX_PAYLOAD)) begin
                  length_in = 7'd0;
                  drop_in   = drop_ff + 32'd1;
                  phase_in  = PH_HEAD1;
               end else begin
                  length_in = rx_byte[6:0];
                  phase_in  = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
               end
            end
            PH_DATA: begin
               sum_in  = sum_next;
               fill_in = fill_next;
               if (fill_next >= length_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_in = PH_HEAD1;
               if (rx_byte != sum_ff || held_ff) begin
                  drop_in = drop_ff + 32'd1;
               end else begin
                  held_in = 1'b1;
               end
            end
            default: begin
               phase_in = (rx_byte == head1) ? PH_HEAD2 : PH_HEAD1;
            end
         endcase
      end
   end

   // result kind and drain index
   always_comb begin
      kind_in   = kind_ff;
      marker_in = marker_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.load_status) begin
         kind_in   = 1'b1;
         marker_in = 1'b0;
      end else if (cmd.load_marker) begin
         kind_in   = 1'b0;
         marker_in = 1'b1;
      end else if (cmd.start_read) begin
         kind_in   = 1'b0;
         marker_in = 1'b0;
         rd_idx_in = '0;
      end else if (cmd.next_read) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEAD1;
         held_ff    <= 1'b0;
         drop_ff    <= '0;
         kind_ff    <= 1'b0;
         marker_ff  <= 1'b0;
         command_ff <= '0;
         length_ff  <= '0;
         fill_ff    <= '0;
         sum_ff     <= '0;
         rd_idx_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         drop_ff    <= drop_in;
         kind_ff    <= kind_in;
         marker_ff  <= marker_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
         rd_idx_ff  <= rd_idx_in;
      end
   end

   // payload store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_ff[AW-1:0]] <= rx_byte;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   assign no_data = kind_ff || marker_ff;

   always_comb begin
      rsp_data.kind          = kind_ff;
      rsp_data.frame_command = kind_ff ? 8'd0 : command_ff;
      rsp_data.frame_length  = kind_ff ? 7'd0 : length_ff;
      rsp_data.byte_index    = no_data ? 6'd0 : 6'(rd_idx_ff);
      rsp_data.payload_byte  = no_data ? 8'd0 : rd_data_ff;
      rsp_data.payload_valid = !no_data;
      rsp_data.last          = no_data || ((7'(rd_idx_ff) + 7'd1) == length_ff);
      rsp_data.error_count   = drop_ff;
      rsp_data.frame_held    = held_ff;
   end

   `CHK_IMPLY(a_held_from_check, clock, reset, $rose(held_ff), $past(phase_ff == PH_CHECK && cmd.take_byte), "held flag set outside the check byte")
   `CHK_IMPLY(a_drop_on_byte, clock, reset, drop_ff != $past(drop_ff), $past(cmd.take_byte), "drop count moved without a byte")

endmodule

// ===== sim/tb_checksummed_frame_deframer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checksummed_frame_deframer
// Self-checking bench for the frame deframer. The byte stream is built from
// framed messages (good, bad check, bad second header, oversize length), mixed
// with releases, status reads, ignored transactions and line noise. An
// in-bench model of the parser predicts every result, and each returned result
// is compared field by field against the oldest prediction. The header
// registers are reprogrammed between phases, and flow control on both sides is
// varied across the phases.
// ----------------------------------------------------------------------------
module tb_checksummed_frame_deframer;
   import cfd_pkg::*;

   // the fourth mode value has no name in the package; the block ignores it
   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         FRAME_MAX      = MAX_PAYLOAD_DEF;
   localparam int         SETTLE_CYCLES  = 8;
   localparam int         WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
   localparam int         MAX_REPORTS    = 10;
   localparam int         RANDOM_PER_PHASE = 80;

   typedef enum {FLAW_NONE, FLAW_CHECK, FLAW_HEAD2, FLAW_LENGTH} frame_flaw_type;

   // one queued request; hold_off makes the sender wait for the result side to drain
   typedef struct {
      req_type txn;
      bit      hold_off;
   } queued_txn_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;
   logic    csr_psel    = 1'b0;
   logic    csr_penable = 1'b0;
   logic    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // stimulus side
   queued_txn_type txn_backlog[$];
   int          txns_queued   = 0;
   int          txns_accepted = 0;
   int unsigned sender_gap_pct     = 9;
   int unsigned receiver_stall_pct = 53;

   // parser model: its own copy of the header registers and of the parse state
   logic [7:0]  sync1_value;
   logic [7:0]  sync2_value;
   phase_type   hunt_phase;
   logic [7:0]  model_command;
   logic [6:0]  model_length;
   logic [6:0]  bytes_taken;
   logic [7:0]  sum_acc;
   logic [7:0]  payload_mem [FRAME_MAX];
   logic        holding;
   logic [31:0] dropped_frames;
   int          frames_delivered = 0;

   // scoreboard
   rsp_type awaited_results[$];
   int      results_owed    = 0;   // registered copy of the queue depth, read by the driver
   int      results_checked = 0;
   int      failures        = 0;
   int      stall_cycles    = 0;

   checksummed_frame_deframer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Parser model. Called once per accepted request transaction; pushes every
   // result that transaction causes onto awaited_results.
   // ------------------------------------------------------------------------
   task automatic advance_deframer(input req_type t);
      rsp_type    r;
      logic [7:0] b;
      r = '0;
      b = t.rx_byte;
      case (t.mode)
         MODE_BYTE: begin
            case (hunt_phase)
               // a wrong second header drops back to hunting; that byte is not
               // looked at again as a possible first header
               PH_HEAD2: hunt_phase = (b == sync2_value) ? PH_CMD : PH_HEAD1;
               PH_CMD: begin
                  model_command = b;
                  sum_acc       = b;
                  hunt_phase    = PH_LEN;
               end
               PH_LEN: begin
                  sum_acc     = sum_acc + b;
                  bytes_taken = '0;
                  if (b > FRAME_MAX) begin
                     // oversize length: counted as a drop right away
                     model_length   = '0;
                     dropped_frames = dropped_frames + 1;
                     hunt_phase     = PH_HEAD1;
                  end else begin
                     model_length = b[6:0];
                     hunt_phase   = (b == 8'd0) ? PH_CHECK : PH_DATA;
                  end
               end
               PH_DATA: begin
                  payload_mem[bytes_taken[5:0]] = b;
                  sum_acc     = sum_acc + b;
                  bytes_taken = bytes_taken + 1;
                  if (bytes_taken >= model_length)
                     hunt_phase = PH_CHECK;
               end
               PH_CHECK: begin
                  hunt_phase = PH_HEAD1;
                  // bad sum, or a good frame while one is still held: dropped
                  if (b != sum_acc || holding) begin
                     dropped_frames = dropped_frames + 1;
                  end else begin
                     holding = 1'b1;
                     frames_delivered++;
                     r.frame_command = model_command;
                     r.error_count   = dropped_frames;
                     r.frame_held    = 1'b1;
                     if (model_length == 0) begin
                        // empty frame: a single marker with no data
                        r.last = 1'b1;
                        awaited_results.push_back(r);
                     end else begin
                        for (int i = 0; i < model_length; i++) begin
                           r.frame_length  = model_length;
                           r.byte_index    = i[5:0];
                           r.payload_byte  = payload_mem[i];
                           r.payload_valid = 1'b1;
                           r.last          = (i == model_length - 1);
                           awaited_results.push_back(r);
                        end
                     end
                  end
               end
               default: hunt_phase = (b == sync1_value) ? PH_HEAD2 : PH_HEAD1;
            endcase
         end
         // release does nothing when no frame is held; the parser sees no byte
         MODE_RELEASE: holding = 1'b0;
         MODE_STATUS: begin
            r.kind        = 1'b1;
            r.last        = 1'b1;
            r.error_count = dropped_frames;
            r.frame_held  = holding;
            awaited_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      string   wrong;
      results_checked++;
      if (awaited_results.size() == 0) begin
         note_failure($sformatf("unexpected result %p", got));
         return;
      end
      want  = awaited_results.pop_front();
      wrong = "";
      if (got.kind          !== want.kind)          wrong = {wrong, " kind"};
      if (got.frame_command !== want.frame_command) wrong = {wrong, " frame_command"};
      if (got.frame_length  !== want.frame_length)  wrong = {wrong, " frame_length"};
      if (got.byte_index    !== want.byte_index)    wrong = {wrong, " byte_index"};
      if (got.payload_byte  !== want.payload_byte)  wrong = {wrong, " payload_byte"};
      if (got.payload_valid !== want.payload_valid) wrong = {wrong, " payload_valid"};
      if (got.last          !== want.last)          wrong = {wrong, " last"};
      if (got.error_count   !== want.error_count)   wrong = {wrong, " error_count"};
      if (got.frame_held    !== want.frame_held)    wrong = {wrong, " frame_held"};
      if (wrong != "")
         note_failure($sformatf("result %0d,%s wrong: expected %p, got %p",
                                results_checked, wrong, want, got));
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents the backlog one transaction at a time. A hold-off entry
   // waits until nothing is in flight and every predicted result has drained.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (txn_backlog.size() != 0 && $urandom_range(99) >= sender_gap_pct &&
             (!txn_backlog[0].hold_off || (!req_valid && results_owed == 0))) begin
            req_data  <= txn_backlog[0].txn;
            req_valid <= 1'b1;
            void'(txn_backlog.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predicts on request handshakes, checks on result handshakes,
   // drives the receiver's random stalls and feeds the watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            advance_deframer(req_data);
            txns_accepted <= txns_accepted + 1;
         end
         if (rsp_valid && rsp_ready)
            compare_result(rsp_data);
         results_owed <= awaited_results.size();
         rsp_ready    <= ($urandom_range(99) >= receiver_stall_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pwrite && csr_pready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // watchdog: no transaction of any kind for too long means the block hung
   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_txn(input logic [1:0] mode, input logic [7:0] data,
                            input bit hold_off = 1'b0);
      queued_txn_type q;
      q.txn.mode    = mode;
      q.txn.rx_byte = data;
      q.hold_off    = hold_off;
      txn_backlog.push_back(q);
      txns_queued++;
   endtask

   // Builds one frame with the current header values. For FLAW_LENGTH, len is
   // the (oversize) length byte itself and the frame stops there.
   task automatic queue_frame(input logic [7:0] cmd, input int len,
                              input frame_flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] data;
      queue_txn(MODE_BYTE, sync1_value);
      if (flaw == FLAW_HEAD2) begin
         queue_txn(MODE_BYTE, sync2_value ^ 8'($urandom_range(1, 255)));
         return;
      end
      queue_txn(MODE_BYTE, sync2_value);
      queue_txn(MODE_BYTE, cmd);
      queue_txn(MODE_BYTE, 8'(len));
      if (flaw == FLAW_LENGTH)
         return;
      sum = cmd + 8'(len);
      for (int i = 0; i < len; i++) begin
         data = 8'($urandom);
         queue_txn(MODE_BYTE, data);
         sum = sum + data;
      end
      queue_txn(MODE_BYTE, (flaw == FLAW_CHECK) ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   // mostly short payloads, some medium, a few at the maximum
   function automatic int pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 4)
         return FRAME_MAX;
      else if (r < 20)
         return $urandom_range(9, FRAME_MAX - 1);
      return $urandom_range(0, 8);
   endfunction

   task automatic queue_random_traffic(input int target);
      int          first;
      int unsigned pick;
      first = txns_queued;
      // start from a drained block, and always include one full-size frame
      queue_txn(MODE_RELEASE, 8'($urandom), 1'b1);
      queue_frame(8'($urandom), FRAME_MAX, FLAW_NONE);
      while (txns_queued - first < target) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            queue_frame(8'($urandom), pick_length(), FLAW_NONE);
            // usually freed right away; otherwise the next good frame collides
            if ($urandom_range(9) < 7)
               queue_txn(MODE_RELEASE, 8'($urandom), $urandom_range(9) == 0);
         end else if (pick < 63)
            queue_frame(8'($urandom), pick_length(), FLAW_CHECK);
         else if (pick < 67)
            queue_frame(8'($urandom), 0, FLAW_HEAD2);
         else if (pick < 71)
            queue_frame(8'($urandom), $urandom_range(FRAME_MAX + 1, 255), FLAW_LENGTH);
         else if (pick < 79)
            queue_txn(MODE_RELEASE, 8'($urandom));
         else if (pick < 88)
            queue_txn(MODE_STATUS, 8'($urandom));
         else if (pick < 95)
            queue_txn(MODE_BYTE, 8'($urandom));   // line noise
         else
            queue_txn(MODE_UNUSED, 8'($urandom));
      end
   endtask

   // APB write: setup cycle, then access until pready; model copy follows
   task automatic write_sync_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_HEAD1: sync1_value = value;
         CSR_HEAD2: sync2_value = value;
         default: ;
      endcase
   endtask

   // every queued transaction taken, every predicted result returned, then a
   // settling wait so the block is truly idle
   task automatic wait_for_quiet();
      do @(posedge clock); while (txns_accepted != txns_queued || results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      sync1_value    = HEAD1_RESET;
      sync2_value    = HEAD2_RESET;
      hunt_phase     = PH_HEAD1;
      model_command  = '0;
      model_length   = '0;
      bytes_taken    = '0;
      sum_acc        = '0;
      holding        = 1'b0;
      dropped_frames = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed checks on the default headers, sender rarely idle, receiver often stalled
      write_sync_reg(CSR_HEAD1, 8'hAA);
      write_sync_reg(CSR_HEAD2, 8'h55);
      @(negedge clock);
      queue_txn(MODE_STATUS, 8'h00);                 // fresh state
      queue_txn(MODE_RELEASE, 8'hFF);                // release with nothing held
      queue_txn(MODE_UNUSED, 8'hA5);                 // ignored mode
      queue_frame(8'hFF, 0, FLAW_NONE);              // empty frame -> marker
      queue_txn(MODE_STATUS, 8'hFF);                 // held flag now set
      queue_frame(8'h00, 0, FLAW_NONE);              // good frame while held -> drop
      queue_txn(MODE_RELEASE, 8'h00);
      queue_txn(MODE_BYTE, sync1_value);             // bad second header that is itself
      queue_txn(MODE_BYTE, sync1_value);             // a first header: not re-examined,
      queue_txn(MODE_BYTE, sync2_value);             // so this byte starts nothing
      queue_frame(8'h3C, 255, FLAW_LENGTH);          // oversize length
      queue_frame(8'h01, 1, FLAW_CHECK);             // wrong check byte
      queue_txn(MODE_STATUS, 8'h5A);                 // drop count so far
      wait_for_quiet();

      // header extremes, same flow control
      write_sync_reg(CSR_HEAD1, 8'h00);
      write_sync_reg(CSR_HEAD2, 8'hFF);
      @(negedge clock);
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_for_quiet();

      // swapped extremes; now the sender idles a lot and the receiver rarely stalls
      write_sync_reg(CSR_HEAD1, 8'hFF);
      write_sync_reg(CSR_HEAD2, 8'h00);
      @(negedge clock);
      sender_gap_pct     = 53;
      receiver_stall_pct = 9;
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_for_quiet();

      // random headers, full throughput on both sides
      write_sync_reg(CSR_HEAD1, 8'($urandom));
      write_sync_reg(CSR_HEAD2, 8'($urandom));
      @(negedge clock);
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_for_quiet();

      if (awaited_results.size() != 0)
         note_failure($sformatf("%0d predicted results never arrived",
                                awaited_results.size()));

      $display("Run summary: %0d request transactions, %0d results checked,",
               txns_accepted, results_checked);
      $display("  %0d frames delivered, %0d frames dropped, 4 header settings, 3 flow profiles",
               frames_delivered, dropped_frames);
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== checksummed_frame_deframer.f =====
+incdir+hdl
hdl/cfd_pkg.sv
hdl/cfd_ctrl.sv
hdl/cfd_datapath.sv
hdl/checksummed_frame_deframer.sv
sim/tb_checksummed_frame_deframer.sv
